[hdl/bfa_pkg.sv]
// bfa_pkg: shared types and constants for the best-fit block allocator
// used by bfa_ctrl, bfa_datapath and best_fit_block_allocator
// no dependencies
package bfa_pkg;

    // defaults for the top level parameters
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    // fixed port field widths
    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int LEFTOVER_W = 16;

    // operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } bfa_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_wr;
        logic scan_start;
        logic scan_step;
        logic commit;
    } bfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic issue_last;
        logic out_free;
    } bfa_sts_t;

endpackage

[hdl/bfa_ram.sv]
// bfa_ram: generic single write port, single read port RAM with registered read
// no dependencies
module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bfa_ctrl.sv]
// bfa_ctrl: sequencer for loads and best-fit scans
// depends on bfa_pkg
module bfa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  bfa_pkg::bfa_sts_t sts,
    output bfa_pkg::bfa_cmd_t cmd
);

    bfa_pkg::bfa_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // s_ready is high throughout idle, so s_valid alone marks an accepted beat there
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfa_pkg::ST_IDLE: begin
                if (s_valid && s_operation == bfa_pkg::OP_REQUEST) begin
                    state_next = bfa_pkg::ST_SCAN;
                end
            end
            bfa_pkg::ST_SCAN: begin
                if (sts.issue_last) begin
                    state_next = bfa_pkg::ST_DRAIN;
                end
            end
            bfa_pkg::ST_DRAIN: begin
                state_next = bfa_pkg::ST_FINISH;
            end
            bfa_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.load_wr    = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            bfa_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_wr    = s_valid && s_operation == bfa_pkg::OP_LOAD;
                cmd.scan_start = s_valid && s_operation == bfa_pkg::OP_REQUEST;
            end
            bfa_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            bfa_pkg::ST_DRAIN: begin
            end
            bfa_pkg::ST_FINISH: begin
                cmd.commit = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/bfa_datapath.sv]
// bfa_datapath: block size RAM, loaded/taken flags, scan compare and result register
// depends on bfa_pkg and bfa_ram
module bfa_datapath #(
    parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = bfa_pkg::SIZE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bfa_pkg::bfa_cmd_t              cmd,
    output bfa_pkg::bfa_sts_t              sts,
    input  logic [bfa_pkg::SLOT_W-1:0]     s_block_slot,
    input  logic [bfa_pkg::AMOUNT_W-1:0]   s_amount,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_granted,
    output logic [bfa_pkg::SLOT_W-1:0]     m_chosen_block,
    output logic [bfa_pkg::LEFTOVER_W-1:0] m_leftover
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    logic [NUM_BLOCKS-1:0] loaded_reg, taken_reg;
    logic [IDX_W-1:0]      scan_idx_reg, cmp_idx_reg, best_idx_reg;
    logic                  cmp_valid_reg, found_reg;
    logic [SIZE_WIDTH-1:0] req_reg, best_size_reg;
    logic [SIZE_WIDTH-1:0] rd_data, load_size;
    logic [IDX_W-1:0]      slot_idx;
    logic                  slot_ok, cand, out_free;

    logic                           m_valid_reg, m_granted_reg;
    logic [bfa_pkg::SLOT_W-1:0]     m_chosen_reg;
    logic [bfa_pkg::LEFTOVER_W-1:0] m_leftover_reg;

    assign slot_idx  = IDX_W'(s_block_slot);
    assign slot_ok   = 32'(s_block_slot) < 32'(NUM_BLOCKS);
    assign load_size = SIZE_WIDTH'(s_amount);

    bfa_ram #(
        .WIDTH(SIZE_WIDTH),
        .DEPTH(NUM_BLOCKS)
    ) u_size_ram (
        .aclk   (aclk),
        .wr_en  (cmd.load_wr && slot_ok),
        .wr_addr(slot_idx),
        .wr_data(load_size),
        .rd_addr(scan_idx_reg),
        .rd_data(rd_data)
    );

    // rd_data belongs to cmp_idx_reg, which holds the address issued in the previous cycle
    assign cand = cmp_valid_reg && loaded_reg[cmp_idx_reg] && !taken_reg[cmp_idx_reg]
                  && rd_data >= req_reg && (!found_reg || rd_data < best_size_reg);

    assign out_free       = !m_valid_reg || m_ready;
    assign sts.out_free   = out_free;
    assign sts.issue_last = scan_idx_reg == LAST_IDX;

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
            req_reg      <= SIZE_WIDTH'(s_amount);
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmd.scan_start) begin
            found_reg <= 1'b0;
        end else if (cand) begin
            found_reg     <= 1'b1;
            best_idx_reg  <= cmp_idx_reg;
            best_size_reg <= rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            loaded_reg    <= '0;
            taken_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.load_wr && slot_ok) begin
                loaded_reg[slot_idx] <= 1'b1;
                taken_reg[slot_idx]  <= 1'b0;
            end else if (cmd.commit && found_reg) begin
                taken_reg[best_idx_reg] <= 1'b1;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_granted_reg <= found_reg;
            if (found_reg) begin
                m_chosen_reg   <= bfa_pkg::SLOT_W'(best_idx_reg);
                m_leftover_reg <= bfa_pkg::LEFTOVER_W'(best_size_reg - req_reg);
            end else begin
                m_chosen_reg   <= '0;
                m_leftover_reg <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_granted      = m_granted_reg;
    assign m_chosen_block = m_chosen_reg;
    assign m_leftover     = m_leftover_reg;

endmodule

[hdl/best_fit_block_allocator.sv]
// best_fit_block_allocator: top level of the best-fit block allocator
// depends on bfa_pkg, bfa_ctrl, bfa_datapath (and bfa_ram below it)
//
// Input channel s_*: s_operation selects a load (block size into slot
// s_block_slot) or an allocation request for s_amount. A load is written
// straight from idle and gives no result beat; loads can be accepted on
// consecutive cycles. A load to a slot at or above NUM_BLOCKS is dropped.
// A request scans all slots through the size RAM, one slot per cycle, and
// picks the smallest free loaded block that fits (lowest slot on a tie).
// The scan state issues each slot address, the drain state compares the
// last slot, and the finish state commits the result to m_*; s_ready is
// low until then, so no new item is taken while a request is in flight.
// The result sits in an output register: while the receiver stalls, loads
// are still accepted, and a following request scans but holds its commit
// until the pending result beat is taken.
// Reset (aresetn low, synchronous) marks every slot unloaded and free and
// empties the output register; block sizes are not cleared, since an
// unloaded slot is never chosen.
module best_fit_block_allocator #(
    parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = bfa_pkg::SIZE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [bfa_pkg::SLOT_W-1:0]     s_block_slot,
    input  logic [bfa_pkg::AMOUNT_W-1:0]   s_amount,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_granted,
    output logic [bfa_pkg::SLOT_W-1:0]     m_chosen_block,
    output logic [bfa_pkg::LEFTOVER_W-1:0] m_leftover
);

    bfa_pkg::bfa_cmd_t cmd;
    bfa_pkg::bfa_sts_t sts;

    bfa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .sts        (sts),
        .cmd        (cmd)
    );

    bfa_datapath #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_block_slot  (s_block_slot),
        .s_amount      (s_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_chosen_block(m_chosen_block),
        .m_leftover    (m_leftover)
    );

endmodule
